/* src/lbs_pkg.sv */
// Shared constants for the linear blend skinning block.
// No dependencies; imported by the bone store, the top level and the checker.
package lbs_pkg;

    localparam int ENTRY_W     = 32;
    localparam int ROW_W       = 3 * ENTRY_W;
    localparam int WEIGHT_W    = 17;
    localparam int FRAC_BITS   = 16;
    localparam int S_TDATA_W   = 128;
    localparam int S_TUSER_W   = 2;
    localparam int M_TDATA_W   = 96;

    localparam logic [WEIGHT_W-1:0] WEIGHT_ONE = 17'h10000;

    // tuser bit positions on the input side
    localparam int TUSER_KIND   = 0;
    localparam int TUSER_NORMAL = 1;

    // request kinds
    localparam logic REQ_LOAD = 1'b0;
    localparam logic REQ_INFL = 1'b1;

endpackage

/* src/lbs_mul.sv */
// Shared signed multiplier with a registered product.
// No dependencies; used by the skinning sequencer for matrix and weight products.
module lbs_mul #(
    parameter int A_W = 32,
    parameter int B_W = 33
) (
    input  logic                     aclk,
    input  logic                     en,
    input  logic signed [A_W-1:0]    a,
    input  logic signed [B_W-1:0]    b,
    output logic signed [A_W+B_W-1:0] p
);

    logic signed [A_W+B_W-1:0] p_reg;

    always_ff @(posedge aclk) begin
        if (en) begin
            p_reg <= a * b;
        end
    end

    assign p = p_reg;

endmodule

/* src/lbs_bone_store.sv */
// Bone matrix row store: one write and one registered read per cycle.
// Depends on lbs_pkg for the row width.
module lbs_bone_store
    import lbs_pkg::*;
#(
    parameter int ROWS   = 256,
    parameter int ADDR_W = 8
) (
    input  logic              aclk,
    input  logic              we,
    input  logic [ADDR_W-1:0] waddr,
    input  logic [ROW_W-1:0]  wdata,
    input  logic [ADDR_W-1:0] raddr,
    output logic [ROW_W-1:0]  rdata
);

    logic [ROW_W-1:0] mem [ROWS];
    logic [ROW_W-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

/* src/linear_blend_skinning.sv */
// Linear blend skinning: a row store of bone matrices, one shared multiplier
// sequenced over the matrix and the weight, and three saturating accumulators.
// Depends on lbs_pkg, lbs_bone_store and lbs_mul.
//
// A load beat on a bone in range writes one matrix row; s_tready stays high.
// An influence beat on a bone in range holds the input from acceptance
// through four row reads of the store's single read port, nine matrix
// products and three weight products through the one shared multiplier, plus
// the translation add, the last accumulate and the emit step. An influence on
// a bone beyond BONE_SLOTS goes straight to the emit step. A result waits
// in the output register and only stalls the block when a second result is
// due before the first is taken. The store needs no clearing after reset; a
// row read before it was written gives undefined results.
module linear_blend_skinning
    import lbs_pkg::*;
#(
    parameter int BONE_SLOTS = 64,
    parameter int COORD_BITS = 32
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    // bone_index[5:0], row_index[7:6], vec_x[39:8], vec_y[71:40], vec_z[103:72],
    // weight[120:104], zero pad
    input  logic [S_TDATA_W-1:0] s_tdata,
    // req_type[0], is_normal[1]
    input  logic [S_TUSER_W-1:0] s_tuser,
    input  logic                 s_tlast,
    output logic                 m_tvalid,
    input  logic                 m_tready,
    // out_x[31:0], out_y[63:32], out_z[95:64]
    output logic [M_TDATA_W-1:0] m_tdata,
    // out_is_normal
    output logic                 m_tuser
);

    localparam int ROWS    = BONE_SLOTS * 4;
    localparam int ADDR_W  = $clog2(ROWS);
    localparam int ACC_W   = COORD_BITS + 16;
    localparam int T_W     = 52;
    localparam int MA_W    = (COORD_BITS > ENTRY_W) ? COORD_BITS : ENTRY_W;
    localparam int MB_W    = ENTRY_W + 1;
    localparam int P_W     = MA_W + MB_W;
    localparam logic [8:0] SLOTS_V = 9'(BONE_SLOTS);

    typedef enum logic [2:0] {
        S_IDLE, S_READ, S_MUL, S_TRN, S_WMUL, S_FIN, S_EMIT
    } state_t;

    state_t state_reg, state_next;

    logic [1:0]                  r_reg, c_reg, pend_c_reg;
    logic                        pend_reg, pend_w_reg;
    logic [5:0]                  bone_reg;
    logic signed [ENTRY_W-1:0]   v_reg [3];
    logic [WEIGHT_W-1:0]         w_reg;
    logic                        normal_reg, last_reg;
    logic signed [T_W-1:0]       t_reg [3];
    logic signed [ACC_W-1:0]     acc_reg [3];
    logic                        m_tvalid_reg;
    logic [M_TDATA_W-1:0]        out_data_reg;
    logic                        out_normal_reg;

    // input unpack
    logic [5:0]          in_bone;
    logic [1:0]          in_row;
    logic [WEIGHT_W-1:0] in_w;
    logic                in_kind, in_bone_ok, s_fire;

    assign in_bone    = s_tdata[5:0];
    assign in_row     = s_tdata[7:6];
    assign in_w       = s_tdata[120:104];
    assign in_kind    = s_tuser[TUSER_KIND];
    assign in_bone_ok = {3'b000, in_bone} < SLOTS_V;
    assign s_tready   = (state_reg == S_IDLE);
    assign s_fire     = s_tvalid && s_tready;

    // bone store
    logic              mem_we;
    logic [9:0]        waddr_full, raddr_full;
    logic [ROW_W-1:0]  rdata;

    assign mem_we     = s_fire && (in_kind == REQ_LOAD) && in_bone_ok;
    assign waddr_full = {2'b00, in_bone, in_row};
    assign raddr_full = {2'b00, bone_reg, r_reg};

    lbs_bone_store #(.ROWS(ROWS), .ADDR_W(ADDR_W)) u_store (
        .aclk  (aclk),
        .we    (mem_we),
        .waddr (waddr_full[ADDR_W-1:0]),
        .wdata (s_tdata[103:8]),
        .raddr (raddr_full[ADDR_W-1:0]),
        .rdata (rdata)
    );

    logic signed [ENTRY_W-1:0] ent [3];
    always_comb begin
        for (int i = 0; i < 3; i++) begin
            ent[i] = rdata[i*ENTRY_W +: ENTRY_W];
        end
    end

    // operand selection
    logic signed [ENTRY_W-1:0]    v_sel, e_sel;
    logic signed [T_W-1:0]        t_sel;
    logic [T_W-COORD_BITS:0]      t_top;
    logic signed [COORD_BITS-1:0] t_clamp;

    always_comb begin
        case (r_reg)
            2'd0:    v_sel = v_reg[0];
            2'd1:    v_sel = v_reg[1];
            default: v_sel = v_reg[2];
        endcase
        case (c_reg)
            2'd0:    begin e_sel = ent[0]; t_sel = t_reg[0]; end
            2'd1:    begin e_sel = ent[1]; t_sel = t_reg[1]; end
            default: begin e_sel = ent[2]; t_sel = t_reg[2]; end
        endcase
        t_top = t_sel[T_W-1:COORD_BITS-1];
        if (&t_top || ~|t_top) begin
            t_clamp = t_sel[COORD_BITS-1:0];
        end else begin
            t_clamp = {t_sel[T_W-1], {(COORD_BITS-1){~t_sel[T_W-1]}}};
        end
    end

    logic                   mul_en;
    logic signed [MA_W-1:0] mul_a;
    logic signed [MB_W-1:0] mul_b;
    logic signed [P_W-1:0]  mul_p, prod_sh;

    always_comb begin
        mul_en = 1'b0;
        mul_a  = MA_W'(v_sel);
        mul_b  = MB_W'(e_sel);
        if (state_reg == S_MUL) begin
            mul_en = 1'b1;
        end else if (state_reg == S_WMUL) begin
            mul_en = 1'b1;
            mul_a  = MA_W'(t_clamp);
            mul_b  = {{(MB_W-WEIGHT_W){1'b0}}, w_reg};
        end
    end

    lbs_mul #(.A_W(MA_W), .B_W(MB_W)) u_mul (
        .aclk (aclk),
        .en   (mul_en),
        .a    (mul_a),
        .b    (mul_b),
        .p    (mul_p)
    );

    assign prod_sh = mul_p >>> FRAC_BITS;

    // saturating accumulate of the pending weighted product
    logic signed [ACC_W:0]   acc_sum;
    logic signed [ACC_W-1:0] acc_sat;

    always_comb begin
        acc_sum = (ACC_W+1)'(acc_reg[pend_c_reg]) + (ACC_W+1)'(prod_sh);
        if (acc_sum[ACC_W] != acc_sum[ACC_W-1]) begin
            acc_sat = {acc_sum[ACC_W], {(ACC_W-1){~acc_sum[ACC_W]}}};
        end else begin
            acc_sat = acc_sum[ACC_W-1:0];
        end
    end

    // emit saturation to 32 bits
    logic [M_TDATA_W-1:0] out_next;

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            if (&acc_reg[i][ACC_W-1:ENTRY_W-1] || ~|acc_reg[i][ACC_W-1:ENTRY_W-1]) begin
                out_next[i*ENTRY_W +: ENTRY_W] = acc_reg[i][ENTRY_W-1:0];
            end else begin
                out_next[i*ENTRY_W +: ENTRY_W] =
                    {acc_reg[i][ACC_W-1], {(ENTRY_W-1){~acc_reg[i][ACC_W-1]}}};
            end
        end
    end

    logic emit_ok, emit_fire;
    assign emit_ok   = !m_tvalid_reg || m_tready;
    assign emit_fire = (state_reg == S_EMIT) && last_reg && emit_ok;

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE: begin
                if (s_fire && in_kind == REQ_INFL) begin
                    state_next = in_bone_ok ? S_READ : S_EMIT;
                end
            end
            S_READ:  state_next = (r_reg == 2'd3) ? S_TRN : S_MUL;
            S_MUL:   if (c_reg == 2'd2) state_next = S_READ;
            S_TRN:   state_next = S_WMUL;
            S_WMUL:  if (c_reg == 2'd2) state_next = S_FIN;
            S_FIN:   state_next = S_EMIT;
            S_EMIT:  if (!last_reg || emit_ok) state_next = S_IDLE;
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= S_IDLE;
            pend_reg     <= 1'b0;
            pend_w_reg   <= 1'b0;
            m_tvalid_reg <= 1'b0;
            r_reg        <= 2'd0;
            c_reg        <= 2'd0;
            for (int i = 0; i < 3; i++) begin
                acc_reg[i] <= '0;
            end
        end else begin
            state_reg  <= state_next;
            pend_reg   <= 1'b0;
            pend_w_reg <= 1'b0;

            if (emit_fire) begin
                m_tvalid_reg <= 1'b1;
            end else if (m_tvalid_reg && m_tready) begin
                m_tvalid_reg <= 1'b0;
            end

            if (pend_reg) begin
                t_reg[pend_c_reg] <= t_reg[pend_c_reg] + T_W'(prod_sh);
            end
            if (pend_w_reg) begin
                acc_reg[pend_c_reg] <= acc_sat;
            end

            unique case (state_reg)
                S_IDLE: begin
                    if (s_fire) begin
                        bone_reg   <= in_bone;
                        v_reg[0]   <= s_tdata[39:8];
                        v_reg[1]   <= s_tdata[71:40];
                        v_reg[2]   <= s_tdata[103:72];
                        w_reg      <= (in_w > WEIGHT_ONE) ? WEIGHT_ONE : in_w;
                        normal_reg <= s_tuser[TUSER_NORMAL];
                        last_reg   <= s_tlast;
                        r_reg      <= 2'd0;
                        c_reg      <= 2'd0;
                        for (int i = 0; i < 3; i++) begin
                            t_reg[i] <= '0;
                        end
                    end
                end
                S_READ: c_reg <= 2'd0;
                S_MUL: begin
                    pend_reg   <= 1'b1;
                    pend_c_reg <= c_reg;
                    c_reg      <= c_reg + 2'd1;
                    if (c_reg == 2'd2) begin
                        r_reg <= r_reg + 2'd1;
                    end
                end
                S_TRN: begin
                    c_reg <= 2'd0;
                    if (!normal_reg) begin
                        for (int i = 0; i < 3; i++) begin
                            t_reg[i] <= t_reg[i] + T_W'(ent[i]);
                        end
                    end
                end
                S_WMUL: begin
                    pend_w_reg <= 1'b1;
                    pend_c_reg <= c_reg;
                    c_reg      <= c_reg + 2'd1;
                end
                S_FIN: ;
                S_EMIT: begin
                    if (emit_fire) begin
                        out_data_reg   <= out_next;
                        out_normal_reg <= normal_reg;
                        for (int i = 0; i < 3; i++) begin
                            acc_reg[i] <= '0;
                        end
                    end
                end
                default: ;
            endcase
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = out_data_reg;
    assign m_tuser  = out_normal_reg;

endmodule

/* src/lbs_checker.sv */
// Port-level checks for linear_blend_skinning, attached by bind.
// Depends on lbs_pkg for the port widths.
module lbs_checker
    import lbs_pkg::*;
(
    input logic                 aclk,
    input logic                 aresetn,
    input logic                 s_tvalid,
    input logic                 s_tready,
    input logic [S_TDATA_W-1:0] s_tdata,
    input logic [S_TUSER_W-1:0] s_tuser,
    input logic                 s_tlast,
    input logic                 m_tvalid,
    input logic                 m_tready,
    input logic [M_TDATA_W-1:0] m_tdata,
    input logic                 m_tuser
);

    // no result beat straight out of reset
    a_reset_idle: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result valid after reset");

    // a held result beat keeps its payload
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("result beat changed while stalled");

    // an influence beat occupies the sequencer
    a_infl_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready && s_tuser[TUSER_KIND] == REQ_INFL |=> !s_tready)
        else $error("input ready straight after an influence beat");

    // a load beat never raises a result
    a_load_quiet: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready && s_tuser[TUSER_KIND] == REQ_LOAD && !m_tvalid
        |=> !m_tvalid)
        else $error("result after a load beat");

    // a new result only comes out of a busy sequencer
    a_result_src: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_tvalid) |-> $past(!s_tready))
        else $error("result raised while input side was idle");

endmodule

bind linear_blend_skinning lbs_checker u_lbs_checker (.*);

/* bench/tb_top.sv */
`timescale 1ns / 100ps
// Self-checking bench for linear_blend_skinning: bone-row loads and skinning influences
// go in on the s_ stream, skinned vertices come back on m_ and are checked field by field.
// Depends on lbs_pkg and the linear_blend_skinning RTL; needs no files or arguments.
module tb_top;
    import lbs_pkg::*;

    localparam int BONES        = 64;
    localparam int COORD_W      = 32;
    localparam int ACC_W        = COORD_W + FRAC_BITS;
    localparam int ITEM_TARGET  = 1200;
    localparam int DRAIN_CYCLES = 40;
    localparam int HOLD_CYCLES  = 300;
    localparam int PRINT_CAP    = 40;
    localparam int Q_ONE        = 32'h0001_0000;
    localparam int Q_MAX        = 32'h7FFF_FFFF;
    localparam int Q_MIN        = 32'h8000_0000;
    localparam int W_ALL_ONES   = (1 << WEIGHT_W) - 1;

    typedef struct packed {
        logic                          kind;
        logic [5:0]                    bone;
        logic [1:0]                    row;
        logic [2:0][ENTRY_W-1:0]       vec;
        logic [WEIGHT_W-1:0]           weight;
        logic                          normal;
        logic                          closes;
    } beat_t;

    typedef struct packed {
        logic [2:0][ENTRY_W-1:0]       xyz;
        logic                          normal;
    } vertex_t;

    logic                 aclk     = 1'b0;
    logic                 aresetn  = 1'b0;
    logic                 s_tvalid = 1'b0;
    logic                 s_tready;
    // bone_index, row_index, vec_x, vec_y, vec_z, weight, zero pad
    logic [S_TDATA_W-1:0] s_tdata  = '0;
    // req_type, is_normal
    logic [S_TUSER_W-1:0] s_tuser  = '0;
    logic                 s_tlast  = 1'b0;
    logic                 m_tvalid;
    logic                 m_tready = 1'b0;
    // out_x, out_y, out_z
    logic [M_TDATA_W-1:0] m_tdata;
    // out_is_normal
    logic                 m_tuser;

    // model state
    logic [2:0][ENTRY_W-1:0] bone_rows [BONES*4];
    logic [3:0]              rows_loaded [BONES];
    longint                  acc [3];
    int                      ready_bones [$];
    vertex_t                 skinned_q [$];

    int  items_sent     = 0;
    int  mismatch_count = 0;
    bit  src_idle_on    = 1'b1;
    bit  snk_idle_on    = 1'b1;
    int  hold_requests  = 0;
    int  hold_served    = 0;
    int  hold_left      = 0;
    int  stall_left     = 0;

    linear_blend_skinning #(
        .BONE_SLOTS (BONES),
        .COORD_BITS (COORD_W)
    ) dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 90) return $urandom_range(1, 3);
        if (r < 97) return $urandom_range(4, 10);
        return $urandom_range(20, 40);
    endfunction

    function automatic longint clamp_to(input longint v, input int bits);
        longint hi;
        longint lo;
        hi = (longint'(1) << (bits - 1)) - 1;
        lo = -hi - 1;
        if (v > hi) return hi;
        if (v < lo) return lo;
        return v;
    endfunction

    // Applies one beat to the model; returns 1 when a vertex closes.
    function automatic bit skin_step(input beat_t b, output vertex_t v);
        longint t;
        longint w;
        int     base;
        int     c;
        int     r;
        v = '0;
        if (b.kind == REQ_LOAD) begin
            bone_rows[b.bone*4 + b.row] = b.vec;
            if (rows_loaded[b.bone] != 4'hF) begin
                rows_loaded[b.bone][b.row] = 1'b1;
                if (rows_loaded[b.bone] == 4'hF) ready_bones.push_back(int'(b.bone));
            end
            return 1'b0;
        end
        w    = longint'((b.weight > WEIGHT_ONE) ? WEIGHT_ONE : b.weight);
        base = b.bone * 4;
        for (c = 0; c < 3; c++) begin
            t = 0;
            for (r = 0; r < 3; r++)
                t += (longint'($signed(b.vec[r])) *
                      longint'($signed(bone_rows[base+r][c]))) >>> FRAC_BITS;
            if (!b.normal) t += longint'($signed(bone_rows[base+3][c]));
            t      = clamp_to(t, COORD_W);
            acc[c] = clamp_to(acc[c] + ((t * w) >>> FRAC_BITS), ACC_W);
        end
        if (!b.closes) return 1'b0;
        for (c = 0; c < 3; c++) begin
            v.xyz[c] = ENTRY_W'(clamp_to(acc[c], 32));
            acc[c]   = 0;
        end
        v.normal = b.normal;
        return 1'b1;
    endfunction

    function automatic beat_t load_row(input int bone, input int row,
                                       input int x, input int y, input int z);
        beat_t b;
        b        = '0;
        b.kind   = REQ_LOAD;
        b.bone   = 6'(bone);
        b.row    = 2'(row);
        b.vec[0] = x;
        b.vec[1] = y;
        b.vec[2] = z;
        return b;
    endfunction

    function automatic beat_t influence(input int bone, input int x, input int y,
                                        input int z, input int w, input bit normal,
                                        input bit closes);
        beat_t b;
        b        = '0;
        b.kind   = REQ_INFL;
        b.bone   = 6'(bone);
        b.vec[0] = x;
        b.vec[1] = y;
        b.vec[2] = z;
        b.weight = WEIGHT_W'(w);
        b.normal = normal;
        b.closes = closes;
        return b;
    endfunction

    function automatic int rand_q16();
        case ($urandom_range(0, 9))
            0:       return int'($urandom);
            1:       return ($urandom_range(0, 1) != 0) ? Q_MAX : Q_MIN;
            2, 3:    return int'($urandom_range(0, 1 << 25)) - (1 << 24);
            default: return int'($urandom_range(0, 1 << 19)) - (1 << 18);
        endcase
    endfunction

    function automatic int rand_weight();
        case ($urandom_range(0, 6))
            0:       return WEIGHT_ONE;
            1:       return $urandom_range(0, W_ALL_ONES);
            default: return $urandom_range(0, WEIGHT_ONE);
        endcase
    endfunction

    task automatic report_mismatch(input string what, input logic [95:0] got,
                                   input logic [95:0] want);
        if (mismatch_count < PRINT_CAP)
            $display("%0t %s: got %0h, expected %0h", $time, what, got, want);
        mismatch_count++;
    endtask

    task automatic send_beat(input beat_t b);
        int      gap;
        vertex_t v;
        gap = src_idle_on ? pick_gap() : 0;
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {{(S_TDATA_W-121){1'b0}}, b.weight, b.vec[2], b.vec[1], b.vec[0],
                     b.row, b.bone};
        s_tuser  <= {b.normal, b.kind};
        s_tlast  <= b.closes;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        if (skin_step(b, v)) skinned_q.push_back(v);
        items_sent++;
    endtask

    task automatic wait_drained();
        int guard;
        guard = 0;
        s_tvalid <= 1'b0;
        while (skinned_q.size() != 0 && guard < 200000) begin
            @(posedge aclk);
            guard++;
        end
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    task automatic send_random_load(input int bone, input int row);
        beat_t b;
        b = load_row(bone, row, rand_q16(), rand_q16(), rand_q16());
        // fields a load ignores
        if ($urandom_range(0, 3) == 0) begin
            b.weight = WEIGHT_W'($urandom_range(0, W_ALL_ONES));
            b.normal = 1'($urandom_range(0, 1));
            b.closes = 1'($urandom_range(0, 1));
        end
        send_beat(b);
    endtask

    task automatic load_bone(input int bone);
        int r;
        for (r = 0; r < 4; r++) send_random_load(bone, r);
    endtask

    task automatic test_identity_bone();
        send_beat(load_row(0, 0, Q_ONE, 0, 0));
        send_beat(load_row(0, 1, 0, Q_ONE, 0));
        send_beat(load_row(0, 2, 0, 0, Q_ONE));
        send_beat(load_row(0, 3, 10 * Q_ONE, -3 * Q_ONE, 32'h0000_8000));
        send_beat(influence(0, 32'h0001_8000, -2 * Q_ONE, 3 * Q_ONE, WEIGHT_ONE, 0, 1));
        send_beat(influence(0, 32'h0001_8000, -2 * Q_ONE, 3 * Q_ONE, WEIGHT_ONE, 1, 1));
        wait_drained();
    endtask

    // full-scale matrix and vectors: saturation and weight above one
    task automatic test_extremes();
        send_beat(load_row(BONES - 1, 0, Q_MAX, Q_MIN, Q_ONE));
        send_beat(load_row(BONES - 1, 1, Q_MIN, Q_MAX, -1));
        send_beat(load_row(BONES - 1, 2, 1, -1, Q_MAX));
        send_beat(load_row(BONES - 1, 3, Q_MAX, Q_MIN, 0));
        send_beat(influence(BONES - 1, Q_MAX, Q_MIN, Q_MAX, W_ALL_ONES, 0, 1));
        send_beat(influence(BONES - 1, Q_MIN, Q_MIN, Q_MIN, 0, 1, 1));
        send_beat(influence(BONES - 1, Q_MAX, Q_MAX, Q_MAX, WEIGHT_ONE, 0, 1));
        wait_drained();
    endtask

    // point and normal influences in one vertex, with a load in between
    task automatic test_mixed_vertex();
        beat_t b;
        b        = load_row(0, 3, -7 * Q_ONE, 2 * Q_ONE, Q_ONE);
        b.weight = WEIGHT_W'(W_ALL_ONES);
        b.normal = 1'b1;
        b.closes = 1'b1;
        send_beat(influence(0, 4 * Q_ONE, Q_ONE, -Q_ONE, 32'h8000, 0, 0));
        send_beat(influence(BONES - 1, 3, -5, 7, 1, 1, 0));
        send_beat(b);
        send_beat(influence(0, -Q_ONE, 5 * Q_ONE, 2 * Q_ONE, 32'h8000, 0, 1));
        send_beat(influence(0, Q_ONE, Q_ONE, Q_ONE, 32'h4000, 0, 0));
        send_beat(influence(0, Q_ONE, -Q_ONE, Q_ONE, 32'hC000, 1, 1));
        wait_drained();
    endtask

    // sink holds off while the source keeps offering closing influences
    task automatic test_backpressure();
        int i;
        src_idle_on = 1'b0;
        hold_requests++;
        for (i = 0; i < 8; i++)
            send_beat(influence(i[0] ? 0 : BONES - 1, rand_q16(), rand_q16(), rand_q16(),
                                rand_weight(), i[1], 1));
        src_idle_on = 1'b1;
        wait_drained();
    endtask

    task automatic test_random_vertices();
        int n;
        int i;
        int pick;
        int bone;
        bit kind_n;
        bit normal;
        for (i = 0; i < 6; i++) load_bone($urandom_range(0, BONES - 1));
        while (items_sent < ITEM_TARGET) begin
            if ($urandom_range(0, 39) == 0) begin
                src_idle_on = ($urandom_range(0, 2) != 0);
                snk_idle_on <= ($urandom_range(0, 2) != 0);
            end
            pick = $urandom_range(0, 99);
            if (pick < 8) begin
                load_bone($urandom_range(0, BONES - 1));
            end else if (pick < 14) begin
                send_random_load($urandom_range(0, BONES - 1), $urandom_range(0, 3));
            end else begin
                n      = $urandom_range(1, 4);
                kind_n = 1'($urandom_range(0, 1));
                for (i = 0; i < n; i++) begin
                    if ($urandom_range(0, 14) == 0)
                        send_random_load($urandom_range(0, BONES - 1), $urandom_range(0, 3));
                    bone   = ready_bones[$urandom_range(0, ready_bones.size() - 1)];
                    normal = ($urandom_range(0, 4) == 0) ? 1'($urandom_range(0, 1)) : kind_n;
                    send_beat(influence(bone, rand_q16(), rand_q16(), rand_q16(),
                                        rand_weight(), normal, i == n - 1));
                end
            end
        end
        wait_drained();
    endtask

    // sink: random stalls plus one long counted hold-off on request
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else if (hold_served != hold_requests) begin
            hold_served++;
            hold_left = HOLD_CYCLES;
            m_tready <= 1'b0;
        end else if (hold_left > 0) begin
            hold_left--;
            m_tready <= 1'b0;
        end else if (stall_left > 0) begin
            stall_left--;
            m_tready <= 1'b0;
        end else begin
            m_tready <= 1'b1;
            if (snk_idle_on && $urandom_range(0, 3) == 0) stall_left = pick_gap();
        end
    end

    // result checker
    always @(posedge aclk) begin
        vertex_t want;
        if (aresetn && m_tvalid && m_tready) begin
            if (skinned_q.size() == 0) begin
                report_mismatch("unexpected beat", m_tdata, '0);
            end else begin
                want = skinned_q.pop_front();
                if (m_tdata[31:0] !== want.xyz[0]) report_mismatch("out_x",
                    96'(m_tdata[31:0]), 96'(want.xyz[0]));
                if (m_tdata[63:32] !== want.xyz[1]) report_mismatch("out_y",
                    96'(m_tdata[63:32]), 96'(want.xyz[1]));
                if (m_tdata[95:64] !== want.xyz[2]) report_mismatch("out_z",
                    96'(m_tdata[95:64]), 96'(want.xyz[2]));
                if (m_tuser !== want.normal) report_mismatch("out_is_normal",
                    96'(m_tuser), 96'(want.normal));
            end
        end
    end

    initial begin
        #10_000_000;
        $display("linear_blend_skinning: mismatch");
        $finish;
    end

    initial begin
        vertex_t lost_v;
        for (int b = 0; b < BONES; b++) rows_loaded[b] = 4'h0;
        for (int c = 0; c < 3; c++) acc[c] = 0;
        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        test_identity_bone();
        test_extremes();
        test_mixed_vertex();
        test_backpressure();
        test_random_vertices();

        while (skinned_q.size() != 0) begin
            lost_v = skinned_q.pop_front();
            report_mismatch("missing beat", '0, lost_v.xyz);
        end
        if (mismatch_count == 0) begin
            $display("linear_blend_skinning: match");
        end else begin
            $display("linear_blend_skinning: mismatch");
        end
        $finish;
    end

endmodule
